// ===== src/lnpq_pkg.sv =====
// Shared types, constants and the linearization table of the Lab palette quantizer.
package lnpq_pkg;

	localparam int NUM_REGS  = 8;
	localparam int IDX_W     = 3;
	localparam int COLOR_W   = 24;
	localparam int LIN_W     = 17;
	localparam int T_W       = 17;
	localparam int F_W       = 17;
	localparam int CBRT_BITS = 17;
	localparam int LAB_W     = 18;
	localparam int DIST_W    = 38;
	localparam int CONV_LAT  = 25;
	localparam int DIV_SHIFT = 33;

	// White point normalization constants.
	localparam logic [16:0] XN_MUL   = 17'd100000;
	localparam logic [32:0] XN_ADD   = 33'd47523;
	localparam logic [33:0] XN_DIV   = 34'd95047;
	localparam logic [32:0] ZN_ADD   = 33'd54441;
	localparam logic [33:0] ZN_DIV   = 34'd108883;
	localparam logic [16:0] XN_RECIP = 17'((64'd1 << DIV_SHIFT) / 64'd95047);
	localparam logic [16:0] ZN_RECIP = 17'((64'd1 << DIV_SHIFT) / 64'd108883);

	// Linear segment of the Lab companding law.
	localparam logic [T_W-1:0] F_SMALL_MAX = 17'd580;
	localparam logic [22:0]    F_SLOPE     = 23'd7787;
	localparam logic [22:0]    F_ROUND     = 23'd500;
	localparam logic [F_W-1:0] F_OFFSET    = 17'd9039;
	localparam logic [23:0]    F_RECIP     = 24'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);

	localparam logic [0:2][0:2][15:0] MAT = '{
		'{16'd27027, 16'd23436, 16'd11829},
		'{16'd13933, 16'd46871, 16'd4732},
		'{16'd1265,  16'd7812,  16'd62292}
	};

	localparam logic [0:NUM_REGS-1][COLOR_W-1:0] BASE_RESET = '{
		24'h000000, 24'hcd0000, 24'h00cd00, 24'hcdcd00,
		24'h0000ff, 24'hcd00cd, 24'hcd00cd, 24'he5e5e5
	};

	typedef logic signed [LAB_W-1:0] lab_ch_t;

	typedef struct packed {
		lab_ch_t l;
		lab_ch_t a;
		lab_ch_t b;
	} lab_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef logic [255:0][LIN_W-1:0] lin_rom_t;

	// sRGB decoding of one channel to Q16, evaluated only while the table is built.
	function automatic logic [LIN_W-1:0] lin_calc(input logic [7:0] c);
		logic [63:0] t, t2, t4, t8, t12, lo, hi, mid, u, u2, u4, u5;
		if (c <= 8'd10) begin
			return LIN_W'(({56'd0, c} * 64'd6553600 + 64'd164730) / 64'd329460);
		end
		t = ((({56'd0, c} * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
		t2 = (t * t) >> 30;
		t4 = (t2 * t2) >> 30;
		t8 = (t4 * t4) >> 30;
		t12 = (t8 * t4) >> 30;
		lo = 64'd0;
		hi = 64'd65536;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			u = mid << 14;
			u2 = (u * u) >> 30;
			u4 = (u2 * u2) >> 30;
			u5 = (u4 * u) >> 30;
			if (u5 <= t12) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return LIN_W'(lo);
	endfunction

	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		for (int i = 0; i < 256; i++) begin
			rom[i] = lin_calc(8'(i));
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ===== src/lnpq_cbrt_cell.sv =====
// One cell of the cube root chain: decides one result bit and tracks its square and cube.
module lnpq_cbrt_cell import lnpq_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [T_W-1:0]       t_in,
	input  logic [CBRT_BITS-1:0] y_in,
	input  logic [33:0]          y2_in,
	input  logic [48:0]          y3_in,
	output logic [T_W-1:0]       t_out,
	output logic [CBRT_BITS-1:0] y_out,
	output logic [33:0]          y2_out,
	output logic [48:0]          y3_out
);

	logic [51:0] cube;
	logic [51:0] target;
	logic        take;
	logic [T_W-1:0]       t_q;
	logic [CBRT_BITS-1:0] y_q;
	logic [33:0]          y2_q;
	logic [48:0]          y3_q;

	// (y + 2^BIT)^3 built from the running square and cube with shifts and adds.
	always_comb begin
		cube = 52'(y3_in) + ((52'(y2_in) * 52'd3) << BIT)
			+ ((52'(y_in) * 52'd3) << (2 * BIT)) + (52'd1 << (3 * BIT));
		target = {3'd0, t_in, 32'd0};
		take = (cube <= target);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_q <= t_in;
			if (take) begin
				y_q <= y_in | (CBRT_BITS'(1) << BIT);
				y2_q <= y2_in + (34'(y_in) << (BIT + 1)) + (34'd1 << (2 * BIT));
				y3_q <= cube[48:0];
			end else begin
				y_q <= y_in;
				y2_q <= y2_in;
				y3_q <= y3_in;
			end
		end
	end

	assign t_out = t_q;
	assign y_out = y_q;
	assign y2_out = y2_q;
	assign y3_out = y3_q;

endmodule

// ===== src/lnpq_lab_conv.sv =====
// Pipelined sRGB to CIELAB converter with a tag carried alongside each transaction.
module lnpq_lab_conv import lnpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [COLOR_W-1:0] rgb,
	input  tag_t               tag_in,
	output lab_t               lab_out,
	output tag_t               tag_out
);

	localparam int DLY_N = 15;

	logic [2:0][LIN_W-1:0]   lin_s1;
	logic [2:0][2:0][32:0]   prod_s2;
	logic [2:0][16:0]        xyz_s3;
	logic [32:0]             nx_s4, nz_s4, nx_s5, nz_s5, nx_s6, nz_s6;
	logic [16:0]             y_s4, y_s5, y_s6;
	logic [16:0]             qx_s5, qz_s5, qx_s6, qz_s6;
	logic [33:0]             mx_s6, mz_s6;
	logic [2:0][T_W-1:0]     t_s7;
	logic [2:0][22:0]        v_s8;
	logic [2:0][F_W-1:0]     flin_s9;
	tag_t                    tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	tag_t                    tag_s8, tag_s9;
	logic [2:0][F_W-1:0]     flin_dly_q [DLY_N];
	tag_t                    tag_dly_q [DLY_N];
	lab_t                    lab_s25;
	tag_t                    tag_s25;

	logic [2:0][33:0]        xyz_sum;
	logic [49:0]             px, pz;
	logic [33:0]             rx, rz;
	logic [2:0][46:0]        pv;
	logic [2:0][F_W-1:0]     f_sel;
	logic [24:0]             l_raw;
	logic signed [LAB_W-1:0] dxy, dyz;
	logic signed [27:0]      a_raw, b_raw;

	logic [T_W-1:0]       t_ch  [3][CBRT_BITS+1];
	logic [CBRT_BITS-1:0] y_ch  [3][CBRT_BITS+1];
	logic [33:0]          y2_ch [3][CBRT_BITS];
	logic [48:0]          y3_ch [3][CBRT_BITS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xyz_sum[i] = 34'(prod_s2[i][0]) + 34'(prod_s2[i][1]) + 34'(prod_s2[i][2])
				+ 34'd32768;
		end
		px = 50'(nx_s4) * 50'(XN_RECIP);
		pz = 50'(nz_s4) * 50'(ZN_RECIP);
		rx = 34'(nx_s6) - mx_s6;
		rz = 34'(nz_s6) - mz_s6;
		for (int i = 0; i < 3; i++) begin
			pv[i] = 47'(v_s8[i]) * 47'(F_RECIP);
			f_sel[i] = (t_ch[i][CBRT_BITS] <= F_SMALL_MAX) ? flin_dly_q[DLY_N-1][i]
				: y_ch[i][CBRT_BITS];
		end
		l_raw = 25'(f_sel[1]) * 25'd116 + 25'd128;
		dxy = $signed({1'b0, f_sel[0]}) - $signed({1'b0, f_sel[1]});
		dyz = $signed({1'b0, f_sel[1]}) - $signed({1'b0, f_sel[2]});
		a_raw = 28'(dxy) * 28'sd500 + 28'sd128;
		b_raw = 28'(dyz) * 28'sd200 + 28'sd128;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= LIN_ROM[rgb[23:16]];
			lin_s1[1] <= LIN_ROM[rgb[15:8]];
			lin_s1[2] <= LIN_ROM[rgb[7:0]];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= 33'(lin_s1[j]) * 33'(MAT[i][j]);
				end
				xyz_s3[i] <= xyz_sum[i][32:16];
			end
			nx_s4 <= 33'(xyz_s3[0]) * 33'(XN_MUL) + XN_ADD;
			nz_s4 <= 33'(xyz_s3[2]) * 33'(XN_MUL) + ZN_ADD;
			y_s4 <= xyz_s3[1];
			qx_s5 <= px[49:DIV_SHIFT];
			qz_s5 <= pz[49:DIV_SHIFT];
			nx_s5 <= nx_s4;
			nz_s5 <= nz_s4;
			y_s5 <= y_s4;
			mx_s6 <= 34'(qx_s5) * XN_DIV;
			mz_s6 <= 34'(qz_s5) * ZN_DIV;
			qx_s6 <= qx_s5;
			qz_s6 <= qz_s5;
			nx_s6 <= nx_s5;
			nz_s6 <= nz_s5;
			y_s6 <= y_s5;
			// The reciprocal estimate is low by at most one.
			t_s7[0] <= qx_s6 + 17'(rx >= XN_DIV);
			t_s7[1] <= y_s6;
			t_s7[2] <= qz_s6 + 17'(rz >= ZN_DIV);
			for (int i = 0; i < 3; i++) begin
				v_s8[i] <= 23'(t_s7[i][9:0]) * F_SLOPE + F_ROUND;
				flin_s9[i] <= 17'(pv[i][46:DIV_SHIFT]) + F_OFFSET;
			end
			flin_dly_q[0] <= flin_s9;
			for (int k = 1; k < DLY_N; k++) begin
				flin_dly_q[k] <= flin_dly_q[k-1];
			end
			lab_s25.l <= $signed(18'(l_raw >> 8) - 18'd4096);
			lab_s25.a <= 18'(a_raw >>> 8);
			lab_s25.b <= 18'(b_raw >>> 8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
			for (int k = 0; k < DLY_N; k++) begin
				tag_dly_q[k] <= '0;
			end
			tag_s25 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= tag_s8;
			tag_dly_q[0] <= tag_s9;
			for (int k = 1; k < DLY_N; k++) begin
				tag_dly_q[k] <= tag_dly_q[k-1];
			end
			tag_s25 <= tag_dly_q[DLY_N-1];
		end
	end

	// One chain of cube root cells per channel, most significant bit first.
	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		assign t_ch[ch][0] = t_s7[ch];
		assign y_ch[ch][0] = '0;
		assign y2_ch[ch][0] = '0;
		assign y3_ch[ch][0] = '0;
		for (genvar p = 0; p < CBRT_BITS; p++) begin : g_cell
			if (p < CBRT_BITS - 1) begin : g_mid
				lnpq_cbrt_cell #(.BIT(CBRT_BITS - 1 - p)) u_cell (
					.clk    (clk),
					.en     (en),
					.t_in   (t_ch[ch][p]),
					.y_in   (y_ch[ch][p]),
					.y2_in  (y2_ch[ch][p]),
					.y3_in  (y3_ch[ch][p]),
					.t_out  (t_ch[ch][p+1]),
					.y_out  (y_ch[ch][p+1]),
					.y2_out (y2_ch[ch][p+1]),
					.y3_out (y3_ch[ch][p+1])
				);
			end else begin : g_last
				lnpq_cbrt_cell #(.BIT(CBRT_BITS - 1 - p)) u_cell (
					.clk    (clk),
					.en     (en),
					.t_in   (t_ch[ch][p]),
					.y_in   (y_ch[ch][p]),
					.y2_in  (y2_ch[ch][p]),
					.y3_in  (y3_ch[ch][p]),
					.t_out  (t_ch[ch][p+1]),
					.y_out  (y_ch[ch][p+1]),
					.y2_out (),
					.y3_out ()
				);
			end
		end
	end

	assign lab_out = lab_s25;
	assign tag_out = tag_s25;

endmodule

// ===== src/lab_nearest_palette_quantizer_unit.sv =====
// Top level of the Lab palette quantizer: palette registers, distance search and handshake.
// A result is offered once its pixel has passed the converter, the pixel delay line and the search stages.
// Throughput: one pixel per clock; the pipeline only holds when a finished result is stalled.
// The palette converter refreshes one palette entry per clock, so a written entry takes
// effect before any pixel accepted after the write reaches the search.
// Reset loads the default palette and empties the pipeline; stored Lab values need no reset.
module lab_nearest_palette_quantizer_unit import lnpq_pkg::*; #(
	parameter int PALETTE_SIZE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [COLOR_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COLOR_W-1:0] pixel_rgb,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   nearest_index,
	output logic               contrast_white
);

	localparam int CNT = (PALETTE_SIZE < NUM_REGS) ? PALETTE_SIZE : NUM_REGS;
	localparam int PIX_DLY = 9;

	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dsum;
	} node_t;

	function automatic node_t pick(input node_t lo_n, input node_t hi_n);
		// A valid higher index wins over an invalid lower one, and otherwise only on a strictly smaller distance.
		return (hi_n.vld && (!lo_n.vld || hi_n.dsum < lo_n.dsum)) ? hi_n : lo_n;
	endfunction

	logic [COLOR_W-1:0] base_q [NUM_REGS];
	logic [IDX_W-1:0]   idx_q;
	lab_t               pal_q [NUM_REGS];
	lab_t               pal_lab;
	tag_t               pal_tag;
	lab_t               pix_lab;
	tag_t               pix_tag;
	tag_t               pix_tag_in;
	logic               pipe_en;

	lab_t               pix_dly_q [PIX_DLY];
	logic [PIX_DLY-1:0] vld_dly_q;
	logic [36:0]        sq_d1 [NUM_REGS][3];
	node_t              node_d2 [NUM_REGS];
	node_t              node_d3 [4];
	node_t              node_d4 [2];
	node_t              node_d5;
	logic               v_d1, v_d2, v_d3, v_d4, v_d5;
	logic               white_d3, white_d4, white_d5;
	logic               out_valid_q;
	logic [IDX_W-1:0]   nearest_q;
	logic               white_q;

	logic signed [LAB_W:0] diff [NUM_REGS][3];

	assign pipe_en = !(out_valid_q && out_stall && v_d5);
	assign in_stall = !pipe_en;
	assign pix_tag_in = '{vld: in_valid, idx: '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				base_q[i] <= BASE_RESET[i];
			end
			idx_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				base_q[cfg_index] <= cfg_data;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	lnpq_lab_conv u_pal_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (1'b1),
		.rgb     (base_q[idx_q]),
		.tag_in  ('{vld: 1'b1, idx: idx_q}),
		.lab_out (pal_lab),
		.tag_out (pal_tag)
	);

	lnpq_lab_conv u_pix_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.rgb     (pixel_rgb),
		.tag_in  (pix_tag_in),
		.lab_out (pix_lab),
		.tag_out (pix_tag)
	);

	always_ff @(posedge clk) begin
		if (pal_tag.vld) begin
			pal_q[pal_tag.idx] <= pal_lab;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			diff[i][0] = 19'(pix_dly_q[PIX_DLY-1].l) - 19'(pal_q[i].l);
			diff[i][1] = 19'(pix_dly_q[PIX_DLY-1].a) - 19'(pal_q[i].a);
			diff[i][2] = 19'(pix_dly_q[PIX_DLY-1].b) - 19'(pal_q[i].b);
		end
	end

	// Datapath of the search; the pixel is held back until palette updates have landed.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pix_dly_q[0] <= pix_lab;
			for (int k = 1; k < PIX_DLY; k++) begin
				pix_dly_q[k] <= pix_dly_q[k-1];
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				for (int c = 0; c < 3; c++) begin
					sq_d1[i][c] <= 37'(diff[i][c] * diff[i][c]);
				end
				node_d2[i].vld <= (i < CNT);
				node_d2[i].idx <= IDX_W'(i);
				node_d2[i].dsum <= DIST_W'(sq_d1[i][0]) + DIST_W'(sq_d1[i][1])
					+ DIST_W'(sq_d1[i][2]);
			end
			for (int i = 0; i < 4; i++) begin
				node_d3[i] <= pick(node_d2[2*i], node_d2[2*i+1]);
			end
			white_d3 <= !(node_d2[0].dsum < node_d2[NUM_REGS-1].dsum);
			node_d4[0] <= pick(node_d3[0], node_d3[1]);
			node_d4[1] <= pick(node_d3[2], node_d3[3]);
			white_d4 <= white_d3;
			node_d5 <= pick(node_d4[0], node_d4[1]);
			white_d5 <= white_d4;
		end
		if (pipe_en && v_d5) begin
			nearest_q <= node_d5.idx;
			white_q <= white_d5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
			v_d4 <= 1'b0;
			v_d5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pipe_en) begin
				vld_dly_q <= {vld_dly_q[PIX_DLY-2:0], pix_tag.vld};
				v_d1 <= vld_dly_q[PIX_DLY-1];
				v_d2 <= v_d1;
				v_d3 <= v_d2;
				v_d4 <= v_d3;
				v_d5 <= v_d4;
			end
			if (pipe_en && v_d5) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign nearest_index = nearest_q;
	assign contrast_white = white_q;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output side can move");

	a_index_in_palette: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nearest_index <= IDX_W'(CNT - 1)))
		else $error("nearest index beyond the searched palette");

	a_refresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		pal_tag.vld |-> (pal_tag.idx == idx_q - IDX_W'(CONV_LAT)))
		else $error("palette refresh result lands on the wrong entry");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the Lab nearest-palette quantizer: directed table, random pixels.
`timescale 1ns / 1ps
module tb_top;
	import lnpq_pkg::*;

	typedef struct {
		logic [COLOR_W-1:0] pixel;
		bit                 typed;
		logic [IDX_W-1:0]   idx;
		logic               white;
	} pixel_row_t;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic             white;
	} match_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [COLOR_W-1:0] pixel_rgb = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [IDX_W-1:0]   nearest_index;
	logic               contrast_white;

	logic [COLOR_W-1:0] palette [NUM_REGS];
	match_t             pending_matches [$];
	int                 error_count = 0;
	bit                 steady = 1'b0;

	always #2 clk = ~clk;

	lab_nearest_palette_quantizer_unit #(.PALETTE_SIZE(8)) uut (.*);

	// sRGB channel to linear Q16, by bisection on the fifth power in Q30.
	function automatic longint srgb_to_linear(int c);
		longint unsigned t, t2, t4, t8, t12, lo, hi, mid, u, u2, u4;
		if (c <= 10)
			return (longint'(c) * 6553600 + 164730) / 329460;
		t = (((longint'(c) * 1000 + 14025) << 30) + 134512) / 269025;
		t2 = (t * t) >> 30;
		t4 = (t2 * t2) >> 30;
		t8 = (t4 * t4) >> 30;
		t12 = (t8 * t4) >> 30;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			u = mid << 14;
			u2 = (u * u) >> 30;
			u4 = (u2 * u2) >> 30;
			if (((u4 * u) >> 30) <= t12)
				lo = mid;
			else
				hi = mid - 1;
		end
		return longint'(lo);
	endfunction

	function automatic longint companding(longint t);
		longint unsigned target, lo, hi, mid;
		if (t <= 580)
			return (7787 * t + 500) / 1000 + 9039;
		target = longint'(t) << 32;
		lo = 0;
		hi = 131071;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * mid <= target)
				lo = mid;
			else
				hi = mid - 1;
		end
		return longint'(lo);
	endfunction

	// Rounds a value with 8 extra fractional bits, halves toward plus infinity.
	function automatic longint drop_q8(longint v);
		longint w;
		w = v + 128;
		if (w >= 0)
			return w / 256;
		return -((-w + 255) / 256);
	endfunction

	function automatic void rgb_to_lab(logic [COLOR_W-1:0] rgb, output longint lab [3]);
		longint r, g, b, x, y, z, fx, fy, fz;
		r = srgb_to_linear(rgb[23:16]);
		g = srgb_to_linear(rgb[15:8]);
		b = srgb_to_linear(rgb[7:0]);
		x = (27027 * r + 23436 * g + 11829 * b + 32768) >>> 16;
		y = (13933 * r + 46871 * g + 4732 * b + 32768) >>> 16;
		z = (1265 * r + 7812 * g + 62292 * b + 32768) >>> 16;
		fx = companding((x * 100000 + 47523) / 95047);
		fy = companding(y);
		fz = companding((z * 100000 + 54441) / 108883);
		lab[0] = drop_q8(116 * fy) - 4096;
		lab[1] = drop_q8(500 * (fx - fy));
		lab[2] = drop_q8(200 * (fy - fz));
	endfunction

	function automatic longint lab_distance(logic [COLOR_W-1:0] p, logic [COLOR_W-1:0] q);
		longint lp [3], lq [3];
		longint s;
		rgb_to_lab(p, lp);
		rgb_to_lab(q, lq);
		s = 0;
		for (int i = 0; i < 3; i++)
			s += (lp[i] - lq[i]) * (lp[i] - lq[i]);
		return s;
	endfunction

	function automatic match_t nearest_match(logic [COLOR_W-1:0] p);
		match_t m;
		longint d, best_d, d_black, d_white;
		m.idx = '0;
		best_d = 0;
		for (int i = 0; i < NUM_REGS; i++) begin
			d = lab_distance(p, palette[i]);
			if (i == 0 || d < best_d) begin
				m.idx = IDX_W'(i);
				best_d = d;
			end
		end
		d_black = lab_distance(p, palette[0]);
		d_white = lab_distance(p, palette[NUM_REGS-1]);
		m.white = (d_black < d_white) ? 1'b0 : 1'b1;
		return m;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		match_t m;
		if (out_valid && !out_stall) begin
			if (pending_matches.size() == 0) begin
				report("unexpected transaction", nearest_index, -1);
			end else begin
				m = pending_matches.pop_front();
				if (nearest_index !== m.idx)
					report("nearest_index", nearest_index, m.idx);
				if (contrast_white !== m.white)
					report("contrast_white", contrast_white, m.white);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(99) < 30);
	end

	task automatic send_pixel(logic [COLOR_W-1:0] p, bit typed = 0, match_t want = '{0, 0});
		while (!steady && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_rgb <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_matches.push_back(typed ? want : nearest_match(p));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic load_palette(logic [COLOR_W-1:0] colors [NUM_REGS]);
		wait_drained();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= colors[i];
			palette[i] = colors[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Some 45 percent of pixels lie close to a palette entry so that the search is decided by fine detail.
	task automatic random_pixels(int count);
		logic [COLOR_W-1:0] p;
		for (int k = 0; k < count; k++) begin
			steady = (k >= count / 3 && k < count / 3 + 40);
			if (k == count / 2) begin
				in_valid <= 1'b0;
				while (pending_matches.size() != 0)
					@(posedge clk);
			end
			p = COLOR_W'($urandom());
			if ($urandom_range(99) < 45)
				p = palette[$urandom_range(NUM_REGS-1)] ^ (p & 24'h070707);
			send_pixel(p);
		end
		steady = 1'b0;
	endtask

	pixel_row_t directed_rows [] = '{
		'{24'h000000, 1, 3'd0, 1'b0},
		'{24'he5e5e5, 1, 3'd7, 1'b1},
		'{24'hcd0000, 1, 3'd1, 1'b0},
		'{24'h00cd00, 1, 3'd2, 1'b1},
		'{24'hcdcd00, 1, 3'd3, 1'b1},
		'{24'h0000ff, 1, 3'd4, 1'b0},
		'{24'hcd00cd, 1, 3'd5, 1'b1},
		'{24'hffffff, 1, 3'd7, 1'b1},
		'{24'h0a0a0a, 0, 3'd0, 1'b0},
		'{24'h0b0b0b, 0, 3'd0, 1'b0},
		'{24'hff0000, 0, 3'd0, 1'b0},
		'{24'h00ff00, 0, 3'd0, 1'b0},
		'{24'h0000ff, 0, 3'd0, 1'b0},
		'{24'h808080, 0, 3'd0, 1'b0},
		'{24'h7f7f7f, 0, 3'd0, 1'b0},
		'{24'haa55aa, 0, 3'd0, 1'b0},
		'{24'h55aa55, 0, 3'd0, 1'b0},
		'{24'h010203, 0, 3'd0, 1'b0}
	};

	initial begin
		logic [COLOR_W-1:0] colors [NUM_REGS];
		for (int i = 0; i < NUM_REGS; i++)
			palette[i] = BASE_RESET[i];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
				'{directed_rows[i].idx, directed_rows[i].white});
		random_pixels(150);
		for (int i = 0; i < NUM_REGS; i++)
			colors[i] = COLOR_W'($urandom());
		load_palette(colors);
		random_pixels(150);
		// Every entry equal: the lowest index wins and contrast ties go to white.
		for (int i = 0; i < NUM_REGS; i++)
			colors[i] = 24'h000000;
		load_palette(colors);
		send_pixel(24'h000000, 1, '{3'd0, 1'b1});
		send_pixel(24'hffffff, 1, '{3'd0, 1'b1});
		random_pixels(30);
		for (int i = 0; i < NUM_REGS; i++)
			colors[i] = 24'hffffff;
		load_palette(colors);
		send_pixel(24'h123456, 1, '{3'd0, 1'b1});
		random_pixels(30);
		for (int i = 0; i < NUM_REGS; i++)
			colors[i] = (i % 2 == 0) ? 24'h000000 : 24'hffffff;
		colors[7] = 24'h808080;
		load_palette(colors);
		random_pixels(60);
		for (int i = 0; i < NUM_REGS; i++)
			colors[i] = COLOR_W'($urandom());
		load_palette(colors);
		random_pixels(160);
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("lab_nearest_palette_quantizer_unit verification clean");
		end else begin
			$display("lab_nearest_palette_quantizer_unit verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("lab_nearest_palette_quantizer_unit verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/lnpq_pkg.sv
src/lnpq_cbrt_cell.sv
src/lnpq_lab_conv.sv
src/lab_nearest_palette_quantizer_unit.sv
tb/sv/tb_top.sv
